### src/kedh_pkg.sv
// Package for the key escape decoder with hold.
// Holds payload structs, phase and key enums, register indexes and byte codes.
// No dependencies.
package kedh_pkg;

  localparam int unsigned KEY_COUNT = 7;
  localparam int unsigned HOLD_W = 4;
  localparam int unsigned IDLE_W = 16;

  localparam logic [7:0] BYTE_ESC = 8'd27;
  localparam logic [7:0] BYTE_BRACKET = 8'h5B;

  localparam logic [3:0] HOLD_TICKS_RESET = 4'd8;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd2000;
  localparam logic [15:0] IDLE_COUNT_MAX = 16'hFFFF;

  localparam logic REG_HOLD_TICKS = 1'b0;
  localparam logic REG_IDLE_LIMIT = 1'b1;

  localparam logic ACTION_CHAR = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KEY_UP        = 3'd0,
    KEY_DOWN      = 3'd1,
    KEY_LEFT      = 3'd2,
    KEY_RIGHT     = 3'd3,
    KEY_PRIMARY   = 3'd4,
    KEY_SECONDARY = 3'd5,
    KEY_SKIP      = 3'd6,
    KEY_NONE      = 3'd7
  } key_t;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic up_held;
    logic down_held;
    logic left_held;
    logic right_held;
    logic primary_held;
    logic secondary_held;
    logic skip_held;
    logic interactive;
  } result_t;

  typedef struct packed {
    phase_t phase_next;
    logic   hit;
    key_t   key;
  } dec_t;

endpackage

### src/key_escape_decoder_with_hold_top.sv
// Top level of the key escape decoder with hold: input register, state update,
// result register and configuration port. Depends on kedh_pkg and kedh_decode.
// A tick goes through the input register and then the result register before its result is valid.
// Throughput: one item per cycle unless a tick waits on a stalled result; characters and ticks may follow back to back.
// The result register frees itself in the cycle it is taken, so stall passes back one stage.
// Reset (rst, synchronous): clears phase, hold counters, flag, idle count and both
// valid bits, and restores hold_ticks to 8 and idle_limit to 2000.
module key_escape_decoder_with_hold_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  kedh_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output kedh_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [kedh_pkg::HOLD_W-1:0] hold_ticks;
  logic [kedh_pkg::IDLE_W-1:0] idle_limit;

  logic            item_q_valid;
  kedh_pkg::item_t item_q;

  kedh_pkg::phase_t            phase;
  kedh_pkg::phase_t            phase_next;
  logic [kedh_pkg::HOLD_W-1:0] hold_cnt [kedh_pkg::KEY_COUNT];
  logic [kedh_pkg::HOLD_W-1:0] hold_cnt_next [kedh_pkg::KEY_COUNT];
  logic                        interactive_flag;
  logic                        interactive_flag_next;
  logic [kedh_pkg::IDLE_W-1:0] idle_count;
  logic [kedh_pkg::IDLE_W-1:0] idle_count_next;
  logic [kedh_pkg::IDLE_W-1:0] idle_inc;

  kedh_pkg::dec_t    dec;
  kedh_pkg::result_t result_next;

  logic out_free;
  logic stage_go;
  logic is_tick;
  logic tick_go;
  logic char_go;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= kedh_pkg::HOLD_TICKS_RESET;
      idle_limit <= kedh_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        kedh_pkg::REG_HOLD_TICKS: hold_ticks <= pwdata[kedh_pkg::HOLD_W-1:0];
        kedh_pkg::REG_IDLE_LIMIT: idle_limit <= pwdata[kedh_pkg::IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      kedh_pkg::REG_HOLD_TICKS: prdata = {28'd0, hold_ticks};
      kedh_pkg::REG_IDLE_LIMIT: prdata = {16'd0, idle_limit};
      default:                  prdata = 32'd0;
    endcase
  end

  assign out_free   = !result_valid || !result_stall;
  assign is_tick    = (item_q.action == kedh_pkg::ACTION_TICK);
  assign stage_go   = item_q_valid && (!is_tick || out_free);
  assign tick_go    = stage_go && is_tick;
  assign char_go    = stage_go && !is_tick;
  assign item_stall = item_q_valid && !stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  kedh_decode u_decode (
    .phase     (phase),
    .char_code (item_q.char_code),
    .dec       (dec)
  );

  always_comb begin
    phase_next = phase;
    if (char_go) begin
      phase_next = dec.phase_next;
    end
  end

  always_comb begin
    idle_inc = (idle_count == kedh_pkg::IDLE_COUNT_MAX) ? idle_count
                                                         : idle_count + 1'b1;
    interactive_flag_next = interactive_flag;
    idle_count_next       = idle_count;
    for (int k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
      hold_cnt_next[k] = hold_cnt[k];
    end
    if (char_go) begin
      interactive_flag_next = 1'b1;
      idle_count_next       = '0;
      for (int k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
        if (dec.hit && dec.key == kedh_pkg::key_t'(k)) begin
          hold_cnt_next[k] = hold_ticks;
        end
      end
    end else if (tick_go) begin
      for (int k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
        if (hold_cnt[k] != '0) begin
          hold_cnt_next[k] = hold_cnt[k] - 1'b1;
        end
      end
      if (interactive_flag) begin
        idle_count_next = idle_inc;
        if (idle_inc > idle_limit) begin
          interactive_flag_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result_next.up_held        = (hold_cnt[kedh_pkg::KEY_UP] != '0);
    result_next.down_held      = (hold_cnt[kedh_pkg::KEY_DOWN] != '0);
    result_next.left_held      = (hold_cnt[kedh_pkg::KEY_LEFT] != '0);
    result_next.right_held     = (hold_cnt[kedh_pkg::KEY_RIGHT] != '0);
    result_next.primary_held   = (hold_cnt[kedh_pkg::KEY_PRIMARY] != '0);
    result_next.secondary_held = (hold_cnt[kedh_pkg::KEY_SECONDARY] != '0);
    result_next.skip_held      = (hold_cnt[kedh_pkg::KEY_SKIP] != '0);
    result_next.interactive    = interactive_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= kedh_pkg::PH_IDLE;
      interactive_flag <= 1'b0;
      idle_count       <= '0;
      for (int k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
        hold_cnt[k] <= '0;
      end
    end else begin
      phase            <= phase_next;
      interactive_flag <= interactive_flag_next;
      idle_count       <= idle_count_next;
      for (int k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
        hold_cnt[k] <= hold_cnt_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= tick_go;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      result <= result_next;
    end
  end

  a_char_wakes : assert property (@(posedge clk) disable iff (rst)
    char_go |=> interactive_flag && idle_count == '0)
    else $error("character transaction did not set interactive and clear idle count");

  a_tick_result : assert property (@(posedge clk) disable iff (rst)
    tick_go |=> result_valid)
    else $error("tick transaction produced no result");

  a_csi_entry : assert property (@(posedge clk) disable iff (rst)
    char_go && phase == kedh_pkg::PH_ESC && item_q.char_code == kedh_pkg::BYTE_BRACKET
    |=> phase == kedh_pkg::PH_CSI)
    else $error("ESC [ did not enter CSI phase");

  a_no_tick_when_full : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !tick_go)
    else $error("tick processed while result register held");

endmodule

### src/kedh_decode.sv
// Escape-sequence and plain-key decoder for one received byte.
// Combinational; next phase and decoded key. Depends on kedh_pkg.
module kedh_decode (
  input  kedh_pkg::phase_t phase,
  input  logic [7:0]       char_code,
  output kedh_pkg::dec_t   dec
);

  logic [7:0]    lower;
  kedh_pkg::key_t plain_key;
  kedh_pkg::key_t arrow_key;

  always_comb begin
    lower = char_code;
    if (char_code >= "A" && char_code <= "Z") begin
      lower = char_code + 8'd32;
    end
  end

  always_comb begin
    unique case (lower)
      "w":                       plain_key = kedh_pkg::KEY_UP;
      "s":                       plain_key = kedh_pkg::KEY_DOWN;
      "a":                       plain_key = kedh_pkg::KEY_LEFT;
      "d":                       plain_key = kedh_pkg::KEY_RIGHT;
      "z", " ", 8'h0D, 8'h0A:    plain_key = kedh_pkg::KEY_PRIMARY;
      "x", "c":                  plain_key = kedh_pkg::KEY_SECONDARY;
      "q":                       plain_key = kedh_pkg::KEY_SKIP;
      default:                   plain_key = kedh_pkg::KEY_NONE;
    endcase
  end

  always_comb begin
    unique case (char_code)
      "A":     arrow_key = kedh_pkg::KEY_UP;
      "B":     arrow_key = kedh_pkg::KEY_DOWN;
      "C":     arrow_key = kedh_pkg::KEY_RIGHT;
      "D":     arrow_key = kedh_pkg::KEY_LEFT;
      default: arrow_key = kedh_pkg::KEY_NONE;
    endcase
  end

  // next phase and decoded key
  always_comb begin
    unique case (phase)
      kedh_pkg::PH_ESC: begin
        dec.phase_next = (char_code == kedh_pkg::BYTE_BRACKET) ? kedh_pkg::PH_CSI
                                                                : kedh_pkg::PH_IDLE;
        dec.key = kedh_pkg::KEY_NONE;
      end
      kedh_pkg::PH_CSI: begin
        dec.phase_next = kedh_pkg::PH_IDLE;
        dec.key = arrow_key;
      end
      default: begin
        dec.phase_next = (char_code == kedh_pkg::BYTE_ESC) ? kedh_pkg::PH_ESC
                                                            : kedh_pkg::PH_IDLE;
        dec.key = (char_code == kedh_pkg::BYTE_ESC) ? kedh_pkg::KEY_NONE : plain_key;
      end
    endcase
    dec.hit = (dec.key != kedh_pkg::KEY_NONE);
  end

endmodule

### bench/testbench.sv
// Testbench for key_escape_decoder_with_hold_top: directed and random key traffic with
// an in-bench model of decode, hold timers and the idle timeout, plus APB register tests.
// Depends on kedh_pkg and the RTL under src.
module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 120;
  localparam logic [2:0] ADDR_HOLD_TICKS = {kedh_pkg::REG_HOLD_TICKS, 2'b00};
  localparam logic [2:0] ADDR_IDLE_LIMIT = {kedh_pkg::REG_IDLE_LIMIT, 2'b00};
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  kedh_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  kedh_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // key state mirror
  kedh_pkg::phase_t  esc_phase;
  logic [3:0]        hold_cnt [kedh_pkg::KEY_COUNT];
  logic              user_active;
  logic [15:0]       idle_cnt;
  logic [3:0]        hold_cfg;
  logic [15:0]       limit_cfg;
  kedh_pkg::result_t pending_frames [$];

  int                errors;
  int                cycle_count;
  int                gaps_on;
  int                burst_left;
  int                stall_pct;
  int                stall_run;
  logic              stall_state;
  int                long_hold;
  kedh_pkg::result_t want_frame;
  string             field_name [8] = '{"interactive", "skip_held", "secondary_held",
                                        "primary_held", "right_held", "left_held",
                                        "down_held", "up_held"};

  key_escape_decoder_with_hold_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      result_stall <= 1'b1;
      long_hold--;
    end else begin
      if (stall_run == 0) begin
        stall_state = ($urandom_range(99) < stall_pct);
        stall_run = $urandom_range(6, 1);
      end
      stall_run--;
      result_stall <= stall_state;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %b", $time, result);
      end else begin
        want_frame = pending_frames.pop_front();
        for (int i = 7; i >= 0; i--) begin
          if (want_frame[i] !== result[i]) begin
            errors++;
            $display("%0t: %s expected %b actual %b", $time, field_name[i],
                     want_frame[i], result[i]);
          end
        end
      end
    end
  end

  function automatic kedh_pkg::key_t plain_key(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    case (l)
      "w": return kedh_pkg::KEY_UP;
      "s": return kedh_pkg::KEY_DOWN;
      "a": return kedh_pkg::KEY_LEFT;
      "d": return kedh_pkg::KEY_RIGHT;
      "z", " ", CH_CR, CH_LF: return kedh_pkg::KEY_PRIMARY;
      "x", "c": return kedh_pkg::KEY_SECONDARY;
      "q": return kedh_pkg::KEY_SKIP;
      default: return kedh_pkg::KEY_NONE;
    endcase
  endfunction

  function automatic kedh_pkg::key_t arrow_key(input logic [7:0] c);
    case (c)
      "A": return kedh_pkg::KEY_UP;
      "B": return kedh_pkg::KEY_DOWN;
      "C": return kedh_pkg::KEY_RIGHT;
      "D": return kedh_pkg::KEY_LEFT;
      default: return kedh_pkg::KEY_NONE;
    endcase
  endfunction

  task automatic advance_key_state(input kedh_pkg::item_t it);
    kedh_pkg::key_t    key;
    kedh_pkg::result_t frame;
    int                k;
    if (it.action == kedh_pkg::ACTION_CHAR) begin
      key = kedh_pkg::KEY_NONE;
      user_active = 1'b1;
      idle_cnt = '0;
      case (esc_phase)
        kedh_pkg::PH_ESC: begin
          esc_phase = (it.char_code == kedh_pkg::BYTE_BRACKET) ? kedh_pkg::PH_CSI
                                                                : kedh_pkg::PH_IDLE;
        end
        kedh_pkg::PH_CSI: begin
          key = arrow_key(it.char_code);
          esc_phase = kedh_pkg::PH_IDLE;
        end
        default: begin
          if (it.char_code == kedh_pkg::BYTE_ESC) begin
            esc_phase = kedh_pkg::PH_ESC;
          end else begin
            esc_phase = kedh_pkg::PH_IDLE;
            key = plain_key(it.char_code);
          end
        end
      endcase
      if (key != kedh_pkg::KEY_NONE) hold_cnt[key] = hold_cfg;
    end else begin
      frame.up_held        = (hold_cnt[kedh_pkg::KEY_UP] != 0);
      frame.down_held      = (hold_cnt[kedh_pkg::KEY_DOWN] != 0);
      frame.left_held      = (hold_cnt[kedh_pkg::KEY_LEFT] != 0);
      frame.right_held     = (hold_cnt[kedh_pkg::KEY_RIGHT] != 0);
      frame.primary_held   = (hold_cnt[kedh_pkg::KEY_PRIMARY] != 0);
      frame.secondary_held = (hold_cnt[kedh_pkg::KEY_SECONDARY] != 0);
      frame.skip_held      = (hold_cnt[kedh_pkg::KEY_SKIP] != 0);
      for (k = 0; k < kedh_pkg::KEY_COUNT; k++) begin
        if (hold_cnt[k] != 0) hold_cnt[k] = hold_cnt[k] - 4'd1;
      end
      if (user_active) begin
        if (idle_cnt != kedh_pkg::IDLE_COUNT_MAX) idle_cnt = idle_cnt + 16'd1;
        if (idle_cnt > limit_cfg) user_active = 1'b0;
      end
      frame.interactive = user_active;
      pending_frames.push_back(frame);
    end
  endtask

  task automatic offer_item(input logic act, input logic [7:0] code);
    kedh_pkg::item_t it;
    int              gap;
    it.action = act;
    it.char_code = code;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(6);
      burst_left = $urandom_range(12, 1);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    advance_key_state(it);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    offer_item(kedh_pkg::ACTION_CHAR, c);
  endtask

  task automatic send_tick();
    offer_item(kedh_pkg::ACTION_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_escape(input logic [7:0] c);
    send_char(kedh_pkg::BYTE_ESC);
    send_char(kedh_pkg::BYTE_BRACKET);
    send_char(c);
  endtask

  task automatic set_idling(input int gaps, input int pct);
    gaps_on = gaps;
    stall_pct = pct;
  endtask

  // wait until the block is empty, then let a character in flight finish
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HOLD_TICKS) hold_cfg = data[kedh_pkg::HOLD_W-1:0];
    else if (addr == ADDR_IDLE_LIMIT) limit_cfg = data[kedh_pkg::IDLE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [2:0] addr);
    logic [31:0] want;
    want = (addr == ADDR_HOLD_TICKS) ? 32'(hold_cfg) : 32'(limit_cfg);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register at %0d expected %0d actual %0d", $time, addr, want, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] hold, input logic [15:0] limit);
    settle();
    write_reg(ADDR_HOLD_TICKS, 32'(hold));
    write_reg(ADDR_IDLE_LIMIT, 32'(limit));
    check_reg(ADDR_HOLD_TICKS);
    check_reg(ADDR_IDLE_LIMIT);
  endtask

  function automatic logic [7:0] random_key_byte();
    logic [7:0] b;
    case ($urandom_range(10))
      0: b = "w";
      1: b = "s";
      2: b = "a";
      3: b = "d";
      4: b = "z";
      5: b = "x";
      6: b = "c";
      7: b = "q";
      8: b = " ";
      9: b = CH_CR;
      default: b = CH_LF;
    endcase
    if (b >= "a" && b <= "z" && $urandom_range(1)) b = b - 8'd32;
    return b;
  endfunction

  task automatic test_registers();
    check_reg(ADDR_HOLD_TICKS);
    check_reg(ADDR_IDLE_LIMIT);
    set_config(4'd15, kedh_pkg::IDLE_COUNT_MAX);
    set_config(4'd0, 16'd0);
    set_config(kedh_pkg::HOLD_TICKS_RESET, kedh_pkg::IDLE_LIMIT_RESET);
  endtask

  task automatic test_plain_keys();
    logic [7:0] bytes [14] = '{"w", "S", "a", "D", "Z", " ", CH_CR, CH_LF,
                               "x", "C", "q", "k", 8'h00, 8'hFF};
    for (int i = 0; i < 14; i++) begin
      send_char(bytes[i]);
      if (i % 4 == 3) send_tick();
    end
    repeat (2) send_tick();
  endtask

  task automatic test_arrow_keys();
    set_config(4'd3, kedh_pkg::IDLE_LIMIT_RESET);
    send_escape("A");
    send_tick();
    send_escape("D");
    send_char(kedh_pkg::BYTE_ESC);
    send_char("w");
    send_tick();
    send_escape("x");
    send_escape("B");
    send_escape("C");
    repeat (4) send_tick();
  endtask

  task automatic test_hold_extremes();
    set_config(4'd0, kedh_pkg::IDLE_LIMIT_RESET);
    send_char("w");
    repeat (2) send_tick();
    set_config(4'd1, kedh_pkg::IDLE_LIMIT_RESET);
    send_char("s");
    repeat (2) send_tick();
    set_config(4'd15, kedh_pkg::IDLE_LIMIT_RESET);
    send_char("q");
    repeat (16) send_tick();
  endtask

  task automatic test_idle_limits();
    set_config(kedh_pkg::HOLD_TICKS_RESET, 16'd0);
    send_char("k");
    repeat (2) send_tick();
    send_char("k");
    send_tick();
    set_config(kedh_pkg::HOLD_TICKS_RESET, 16'd1);
    send_char("k");
    repeat (3) send_tick();
  endtask

  task automatic test_large_idle_limit();
    set_idling(0, 0);
    set_config(kedh_pkg::HOLD_TICKS_RESET, kedh_pkg::IDLE_COUNT_MAX);
    send_char("k");
    repeat (40) send_tick();
    settle();
    write_reg(ADDR_IDLE_LIMIT, 32'd0);
    repeat (2) send_tick();
    set_config(kedh_pkg::HOLD_TICKS_RESET, kedh_pkg::IDLE_COUNT_MAX);
    send_tick();
    send_char("k");
    send_tick();
  endtask

  task automatic test_backpressure();
    set_idling(0, 20);
    long_hold = 120;
    repeat (40) begin
      send_tick();
      send_char(random_key_byte());
    end
  endtask

  task automatic random_items(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_tick();
        sent++;
      end else if (pick < 60) begin
        send_char(random_key_byte());
        sent++;
      end else if (pick < 80) begin
        send_char(kedh_pkg::BYTE_ESC);
        if ($urandom_range(9) != 0) begin
          send_char(kedh_pkg::BYTE_BRACKET);
          if ($urandom_range(4) != 0) send_char(8'("A" + $urandom_range(3)));
          else send_char(8'($urandom_range(255)));
          sent += 3;
        end else begin
          send_char(8'($urandom_range(255)));
          sent += 2;
        end
      end else begin
        send_char(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(4'd15, 16'd1);
        1: set_config(4'd1, 16'd65534);
        2: set_config(4'd0, 16'd4);
        3: set_config(kedh_pkg::HOLD_TICKS_RESET, 16'd0);
        4: set_config(4'($urandom_range(15)), kedh_pkg::IDLE_COUNT_MAX);
        default: set_config(4'($urandom_range(15)), 16'($urandom_range(40)));
      endcase
      case (p)
        0: set_idling(0, 0);
        1: set_idling(1, 30);
        2: set_idling(1, 60);
        3: set_idling(0, 80);
        4: set_idling(1, 0);
        default: set_idling(1, 45);
      endcase
      if (p == 2) long_hold = 80;
      random_items(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycle_count = 0;
    gaps_on = 0;
    burst_left = 0;
    stall_pct = 0;
    stall_run = 0;
    stall_state = 1'b0;
    long_hold = 0;
    esc_phase = kedh_pkg::PH_IDLE;
    foreach (hold_cnt[k]) hold_cnt[k] = '0;
    user_active = 1'b0;
    idle_cnt = '0;
    hold_cfg = kedh_pkg::HOLD_TICKS_RESET;
    limit_cfg = kedh_pkg::IDLE_LIMIT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(1, 25);
    test_registers();
    test_plain_keys();
    test_arrow_keys();
    test_hold_extremes();
    test_idle_limits();
    test_large_idle_limit();
    test_backpressure();
    test_random();

    settle();
    repeat (10) @(posedge clk);
    if (pending_frames.size() != 0) begin
      errors++;
      $display("%0t: %0d transactions expected, none arrived", $time, pending_frames.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
